// ===== rtl/vpa_pkg.sv =====
// Shared constants, payload types and control structs of the partition allocator.
`default_nettype none

package vpa_pkg;

  localparam int PARTITIONS = 16;
  localparam int IDX_W      = $clog2(PARTITIONS);
  localparam int SLOT_W     = 4;
  localparam int HEAD_W     = 16;
  localparam int SIZE_W     = 16;
  localparam int JOB_W      = 8;
  localparam int KEY_W      = HEAD_W + IDX_W;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_NEXT  = 2'd1;
  localparam logic [1:0] MODE_BEST  = 2'd2;
  localparam logic [1:0] MODE_WORST = 2'd3;

  localparam logic [1:0] STATUS_LOADED = 2'd0;
  localparam logic [1:0] STATUS_ALLOC  = 2'd1;
  localparam logic [1:0] STATUS_NOFIT  = 2'd2;

  typedef struct packed {
    logic              cmd;
    logic [SLOT_W-1:0] slot;
    logic [HEAD_W-1:0] base_addr;
    logic [SIZE_W-1:0] size;
    logic [JOB_W-1:0]  job_id;
  } vpa_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] chosen_slot;
    logic [SIZE_W-1:0] remaining;
    logic [JOB_W-1:0]  echo_job_id;
  } vpa_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic alloc_start;
    logic scan_step;
    logic commit;
  } vpa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
  } vpa_sts_t;

endpackage

`default_nettype wire

// ===== rtl/vpa_dp.sv =====
// Datapath of the partition allocator: partition table, scan registers and result register.
`default_nettype none

module vpa_dp (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire vpa_pkg::vpa_cmd_t cmd,
  output vpa_pkg::vpa_sts_t     sts,
  input  wire vpa_pkg::vpa_in_t in_data,
  input  wire logic             cfg_wr_en,
  input  wire logic [1:0]       cfg_wr_data,
  output vpa_pkg::vpa_out_t     out_data
);
  import vpa_pkg::*;

  logic [HEAD_W-1:0] part_head_r [PARTITIONS];
  logic [SIZE_W-1:0] part_rest_r [PARTITIONS];
  logic [PARTITIONS-1:0] part_valid_r;

  logic [1:0]        fit_mode_r;
  logic              last_key_valid_r;
  logic [KEY_W-1:0]  last_key_r;

  logic [IDX_W-1:0]  idx_r;
  logic [SIZE_W-1:0] need_r;
  logic [JOB_W-1:0]  job_r;
  logic              best_found_r;
  logic [KEY_W-1:0]  best_key_r;
  logic [SIZE_W-1:0] best_rest_r;
  logic              wrap_found_r;
  logic [KEY_W-1:0]  wrap_key_r;
  logic [SIZE_W-1:0] wrap_rest_r;
  vpa_out_t          out_data_r;

  logic [HEAD_W-1:0] head_rd_r;
  logic [SIZE_W-1:0] rest_rd_r;
  logic [IDX_W-1:0]  rd_addr;
  logic [KEY_W-1:0]  key_rd;
  logic              fit;
  logic              take_best;
  logic              take_wrap;
  logic              sel_found;
  logic [KEY_W-1:0]  sel_key;
  logic [SIZE_W-1:0] sel_rest;
  logic [IDX_W-1:0]  sel_idx;
  logic [SIZE_W-1:0] new_rest;
  logic              slot_ok;
  logic [IDX_W-1:0]  load_idx;

  // One table entry is examined per scan cycle; its words were read at the
  // previous edge, entry zero at the start beat itself.
  always_comb begin
    key_rd  = {head_rd_r, idx_r};
    fit     = part_valid_r[idx_r] && (rest_rd_r >= need_r);
    case (fit_mode_r)
      MODE_FIRST: take_best = fit && (!best_found_r || key_rd < best_key_r);
      MODE_NEXT:  take_best = fit && (!last_key_valid_r || key_rd > last_key_r) &&
                              (!best_found_r || key_rd < best_key_r);
      MODE_BEST:  take_best = fit && (!best_found_r || rest_rd_r < best_rest_r);
      MODE_WORST: take_best = fit && (!best_found_r || rest_rd_r > best_rest_r);
      default:    take_best = 1'b0;
    endcase
    take_wrap = fit && (fit_mode_r == MODE_NEXT) && (!wrap_found_r || key_rd < wrap_key_r);
  end

  // The wrap candidate is only ever set in next fit mode.
  always_comb begin
    sel_found = best_found_r || wrap_found_r;
    sel_key   = best_found_r ? best_key_r : wrap_key_r;
    sel_rest  = best_found_r ? best_rest_r : wrap_rest_r;
    sel_idx   = sel_key[IDX_W-1:0];
    new_rest  = sel_rest - need_r;
    slot_ok   = 32'(in_data.slot) < PARTITIONS;
    load_idx  = IDX_W'(in_data.slot);
    rd_addr   = cmd.alloc_start ? '0 : idx_r + 1'b1;
  end

  assign sts.scan_last = (32'(idx_r) == PARTITIONS - 1);
  assign out_data      = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r       <= MODE_FIRST;
      part_valid_r     <= '0;
      last_key_valid_r <= 1'b0;
      last_key_r       <= '0;
      idx_r            <= '0;
      best_found_r     <= 1'b0;
      wrap_found_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        fit_mode_r <= cfg_wr_data;
      end
      if (cmd.load && slot_ok) begin
        part_valid_r[load_idx] <= 1'b1;
      end
      if (cmd.alloc_start) begin
        idx_r        <= '0;
        best_found_r <= 1'b0;
        wrap_found_r <= 1'b0;
      end
      if (cmd.scan_step) begin
        idx_r <= idx_r + 1'b1;
        if (take_best) begin
          best_found_r <= 1'b1;
        end
        if (take_wrap) begin
          wrap_found_r <= 1'b1;
        end
      end
      if (cmd.commit && sel_found) begin
        last_key_valid_r <= 1'b1;
        last_key_r       <= sel_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && slot_ok) begin
      part_head_r[load_idx] <= in_data.base_addr;
      part_rest_r[load_idx] <= in_data.size;
    end
    if (cmd.commit && sel_found) begin
      part_rest_r[sel_idx] <= new_rest;
    end
    if (cmd.alloc_start || cmd.scan_step) begin
      head_rd_r <= part_head_r[rd_addr];
      rest_rd_r <= part_rest_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_start) begin
      need_r <= in_data.size;
      job_r  <= in_data.job_id;
    end
    if (cmd.scan_step) begin
      if (take_best) begin
        best_key_r  <= key_rd;
        best_rest_r <= rest_rd_r;
      end
      if (take_wrap) begin
        wrap_key_r  <= key_rd;
        wrap_rest_r <= rest_rd_r;
      end
    end
    if (cmd.load) begin
      out_data_r.status      <= STATUS_LOADED;
      out_data_r.chosen_slot <= in_data.slot;
      out_data_r.remaining   <= slot_ok ? in_data.size : '0;
      out_data_r.echo_job_id <= '0;
    end else if (cmd.commit) begin
      out_data_r.echo_job_id <= job_r;
      if (sel_found) begin
        out_data_r.status      <= STATUS_ALLOC;
        out_data_r.chosen_slot <= SLOT_W'(sel_idx);
        out_data_r.remaining   <= new_rest;
      end else begin
        out_data_r.status      <= STATUS_NOFIT;
        out_data_r.chosen_slot <= '0;
        out_data_r.remaining   <= '0;
      end
    end
  end

`ifndef SYNTH
  a_idx_advance: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |=> idx_r == $past(idx_r) + 1'b1)
    else $error("scan index did not advance");
  a_wrap_only_next: assert property (@(posedge clk) disable iff (!rst_n)
    wrap_found_r |-> fit_mode_r == MODE_NEXT || cmd.alloc_start || !cmd.commit)
    else $error("wrap candidate outside next fit");
  a_alloc_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc_start |=> !best_found_r && !wrap_found_r && idx_r == '0)
    else $error("scan state not cleared at allocation start");
`endif

endmodule

`default_nettype wire

// ===== rtl/vpa_ctrl.sv =====
// Controller state machine of the partition allocator.
`default_nettype none

module vpa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              in_cmd,
  output logic                   busy,
  output logic                   out_valid,
  output vpa_pkg::vpa_cmd_t      cmd,
  input  wire vpa_pkg::vpa_sts_t sts
);
  import vpa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   accept;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    cmd.load        = accept && (in_cmd == CMD_LOAD);
    cmd.alloc_start = accept && (in_cmd == CMD_ALLOC);
    cmd.scan_step   = (state_r == S_SCAN);
    cmd.commit      = (state_r == S_COMMIT);
    state_nxt       = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.alloc_start) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.load || cmd.commit;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cmd.load || cmd.commit))
    else $error("result strobe without a finished item");
  a_commit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COMMIT |=> state_r == S_IDLE && out_valid)
    else $error("commit did not return to idle with a result");
  a_scan_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && !sts.scan_last) |=> state_r == S_SCAN)
    else $error("scan left early");
  a_alloc_enters_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc_start |=> state_r == S_SCAN && !out_valid)
    else $error("allocation did not start a scan");
`endif

endmodule

`default_nettype wire

// ===== rtl/variable_partition_allocator.sv =====
// Top level of the variable partition allocator: controller plus datapath.
//
// Usage. The block holds a table of PARTITIONS memory partitions, each with a
// head address, a remaining size and a valid mark. An input beat is taken on a
// rising edge where start is high and busy is low. A load beat (cmd 0) writes
// one slot and marks it valid; an allocate beat (cmd 1) picks a partition for
// the job size by the fit mode and subtracts the job size from it.
// The fit mode is written through cfg_wr_en and cfg_wr_data: first fit, next
// fit, best fit or worst fit. The user must write it only while the block is
// idle; the block itself does not enforce it. Every input beat gives exactly
// one result beat, shown on out_data for one cycle with out_valid high. The
// receiver cannot hold results off. A load result appears the cycle after
// the load is taken and busy stays low, so loads may arrive every cycle. An
// allocation walks the table one entry per cycle through the registered read
// port of the table, read first at the start beat: scan cycles, then a commit
// cycle. Busy stays high through both, so no new beat is taken until the
// allocation's result is registered. Reset (rst_n low, synchronous) clears
// all valid marks, the next-fit position and the fit mode (first fit);
// partition contents need no clearing pass.
`default_nettype none

module variable_partition_allocator (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire vpa_pkg::vpa_in_t in_data,
  output logic                  out_valid,
  output vpa_pkg::vpa_out_t     out_data,
  input  wire logic             cfg_wr_en,
  input  wire logic [1:0]       cfg_wr_data
);
  import vpa_pkg::*;

  vpa_cmd_t cmd;
  vpa_sts_t sts;

  // The controller sequences the scan; the datapath owns all table state.
  vpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_cmd    (in_data.cmd),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  vpa_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the variable partition allocator: directed table, then random phases.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vpa_pkg::*;

  // A cycle with no input beat taken and no result seen counts toward the
  // watchdog. The slowest legitimate quiet stretch is an allocation behind a
  // sender gap and a mode write, so this limit leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS    = 10;
  localparam int RAND_PHASES    = 10;
  localparam int PHASE_BEATS    = 123;
  localparam int N_DIRECTED     = 22;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  vpa_in_t  in_data = '0;
  logic     out_valid;
  vpa_out_t out_data;
  logic     cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = MODE_FIRST;

  // Side-band that travels with each input beat: when set, the result of
  // that beat is checked against a hand-typed value instead of the predictor.
  logic     typed_valid = 1'b0;
  vpa_out_t typed_result = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  variable_partition_allocator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the partition table and the next-fit position.
  // ---------------------------------------------------------------------------
  logic [HEAD_W-1:0] shadow_head [PARTITIONS];
  logic [SIZE_W-1:0] shadow_rest [PARTITIONS];
  logic              shadow_valid[PARTITIONS];
  logic              next_fit_armed;
  logic [KEY_W-1:0]  next_fit_key;
  logic [1:0]        shadow_mode;

  vpa_out_t    pending_results[$];
  int unsigned fail_count = 0;
  int unsigned reported = 0;
  int unsigned stall_cycles = 0;

  // Partitions are ordered by head address, with the slot number breaking ties.
  function automatic logic [KEY_W-1:0] order_key(int s);
    return {shadow_head[s], IDX_W'(s)};
  endfunction

  // Applies one input beat to the shadow table and returns the result the
  // block should produce for it.
  function automatic vpa_out_t apply_to_table(vpa_in_t b);
    vpa_out_t r;
    int pick;
    int wrap;
    r = '0;
    if (b.cmd == CMD_LOAD) begin
      // Every 4-bit slot exists, so a load always lands. A reload keeps the
      // next-fit position untouched.
      shadow_head[b.slot]  = b.base_addr;
      shadow_rest[b.slot]  = b.size;
      shadow_valid[b.slot] = 1'b1;
      r.status      = STATUS_LOADED;
      r.chosen_slot = b.slot;
      r.remaining   = b.size;
      return r;
    end
    r.echo_job_id = b.job_id;
    pick = -1;
    wrap = -1;
    for (int s = 0; s < PARTITIONS; s++) begin
      if (!shadow_valid[s] || shadow_rest[s] < b.size) continue;
      case (shadow_mode)
        MODE_FIRST: begin
          if (pick < 0 || order_key(s) < order_key(pick)) pick = s;
        end
        MODE_NEXT: begin
          // Candidates past the last chosen key win; otherwise the search
          // wraps around to the lowest fitting key.
          if (!next_fit_armed || order_key(s) > next_fit_key) begin
            if (pick < 0 || order_key(s) < order_key(pick)) pick = s;
          end
          if (wrap < 0 || order_key(s) < order_key(wrap)) wrap = s;
        end
        MODE_BEST: begin
          // Strict compare keeps the lowest slot on a tie.
          if (pick < 0 || shadow_rest[s] < shadow_rest[pick]) pick = s;
        end
        default: begin
          if (pick < 0 || shadow_rest[s] > shadow_rest[pick]) pick = s;
        end
      endcase
    end
    if (shadow_mode == MODE_NEXT && pick < 0) pick = wrap;
    if (pick < 0) begin
      // Nothing fits: the table is left alone and only the job id is echoed.
      r.status = STATUS_NOFIT;
      return r;
    end
    shadow_rest[pick] = shadow_rest[pick] - b.size;
    next_fit_key      = order_key(pick);
    next_fit_armed    = 1'b1;
    r.status      = STATUS_ALLOC;
    r.chosen_slot = SLOT_W'(pick);
    r.remaining   = shadow_rest[pick];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge, so it sees the values
  // that the block itself sees at that edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    vpa_out_t want;
    logic     seen;
    if (!rst_n) begin
      for (int s = 0; s < PARTITIONS; s++) begin
        shadow_head[s]  = '0;
        shadow_rest[s]  = '0;
        shadow_valid[s] = 1'b0;
      end
      next_fit_armed = 1'b0;
      next_fit_key   = '0;
      shadow_mode    = MODE_FIRST;
    end else begin
      seen = 1'b0;
      // A result beat is checked against the oldest outstanding expectation.
      if (out_valid) begin
        seen = 1'b1;
        if (pending_results.size() == 0) begin
          fail_count++;
          if (reported < MAX_REPORTS) begin
            reported++;
            $display("%0t: result beat with nothing expected: status %0d slot %0d rem %0d job %0d",
                     $realtime, out_data.status, out_data.chosen_slot,
                     out_data.remaining, out_data.echo_job_id);
          end
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status || out_data.chosen_slot !== want.chosen_slot ||
              out_data.remaining !== want.remaining ||
              out_data.echo_job_id !== want.echo_job_id) begin
            fail_count++;
            if (reported < MAX_REPORTS) begin
              reported++;
              $display("%0t: mismatch: expected status %0d slot %0d rem %0d job %0d",
                       $realtime, want.status, want.chosen_slot, want.remaining,
                       want.echo_job_id);
              $display("%0t:            actual status %0d slot %0d rem %0d job %0d",
                       $realtime, out_data.status, out_data.chosen_slot,
                       out_data.remaining, out_data.echo_job_id);
            end
          end
        end
      end
      if (cfg_wr_en) shadow_mode = cfg_wr_data;
      // An input beat is taken here; the predictor still runs on typed rows
      // so that the shadow table stays in step.
      if (start && !busy) begin
        seen = 1'b1;
        want = apply_to_table(in_data);
        pending_results.push_back(typed_valid ? typed_result : want);
      end
      stall_cycles = seen ? 0 : stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, no beat moved for %0d cycles",
                 $realtime, WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender.
  // ---------------------------------------------------------------------------
  logic gaps_on = 1'b1;

  // Presents one beat and returns on the edge where it is taken. The caller
  // may drive the next beat right away, so start stays high back to back.
  task automatic send_beat(input vpa_in_t b, input logic typed, input vpa_out_t want);
    if (gaps_on && $urandom_range(99) < 12) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start        <= 1'b1;
    in_data      <= b;
    typed_valid  <= typed;
    typed_result <= want;
    do @(posedge clk); while (busy);
  endtask

  // The mode only changes once the block has delivered every result it owes.
  // Every beat gives a result, so an empty queue means the block is idle.
  task automatic write_fit_mode(input logic [1:0] m);
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. Rows with a typed result are ones whose answer is obvious
  // (empty table, loads, extremes, no-fit); the rest go to the predictor.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic       set_mode;
    logic [1:0] mode;
    vpa_in_t    beat;
    logic       typed;
    vpa_out_t   want;
  } dir_row_t;

  localparam vpa_out_t NONE = '0;

  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    // Allocation against an empty table cannot fit.
    '{1'b0, MODE_FIRST, '{CMD_ALLOC, 4'd0, 16'h0000, 16'h0000, 8'h5A},
      1'b1, '{STATUS_NOFIT, 4'd0, 16'h0000, 8'h5A}},
    // Loads at the address and size extremes, job id ignored on a load.
    '{1'b0, MODE_FIRST, '{CMD_LOAD, 4'd0, 16'h0000, 16'hFFFF, 8'h00},
      1'b1, '{STATUS_LOADED, 4'd0, 16'hFFFF, 8'h00}},
    '{1'b0, MODE_FIRST, '{CMD_LOAD, 4'd15, 16'hFFFF, 16'h0000, 8'hFF},
      1'b1, '{STATUS_LOADED, 4'd15, 16'h0000, 8'h00}},
    '{1'b0, MODE_FIRST, '{CMD_LOAD, 4'd5, 16'h1000, 16'd100, 8'h00},
      1'b1, '{STATUS_LOADED, 4'd5, 16'd100, 8'h00}},
    '{1'b0, MODE_FIRST, '{CMD_LOAD, 4'd9, 16'h0800, 16'd100, 8'h00},
      1'b1, '{STATUS_LOADED, 4'd9, 16'd100, 8'h00}},
    '{1'b0, MODE_FIRST, '{CMD_LOAD, 4'd3, 16'h2000, 16'd500, 8'h00},
      1'b1, '{STATUS_LOADED, 4'd3, 16'd500, 8'h00}},
    // Next fit before any allocation starts at the lowest key; size zero fits.
    '{1'b1, MODE_NEXT, '{CMD_ALLOC, 4'd0, 16'h0000, 16'h0000, 8'hFF},
      1'b1, '{STATUS_ALLOC, 4'd0, 16'hFFFF, 8'hFF}},
    // Whole-partition allocation drains slot 0 to zero.
    '{1'b1, MODE_FIRST, '{CMD_ALLOC, 4'd0, 16'h0000, 16'hFFFF, 8'h01},
      1'b1, '{STATUS_ALLOC, 4'd0, 16'h0000, 8'h01}},
    '{1'b0, MODE_FIRST, '{CMD_ALLOC, 4'd0, 16'h0000, 16'hFFFF, 8'h02},
      1'b1, '{STATUS_NOFIT, 4'd0, 16'h0000, 8'h02}},
    '{1'b0, MODE_FIRST, '{CMD_ALLOC, 4'd0, 16'h0000, 16'd50, 8'h03}, 1'b0, NONE},
    // Next fit walks forward in address order, then wraps.
    '{1'b1, MODE_NEXT, '{CMD_ALLOC, 4'd0, 16'h0000, 16'd10, 8'h04}, 1'b0, NONE},
    '{1'b0, MODE_NEXT, '{CMD_ALLOC, 4'd0, 16'h0000, 16'd10, 8'h05}, 1'b0, NONE},
    '{1'b0, MODE_NEXT, '{CMD_ALLOC, 4'd0, 16'h0000, 16'd10, 8'h06}, 1'b0, NONE},
    // Reload of a slot replaces its size but not the next-fit position.
    '{1'b0, MODE_NEXT, '{CMD_LOAD, 4'd9, 16'h0800, 16'd1000, 8'h00},
      1'b1, '{STATUS_LOADED, 4'd9, 16'd1000, 8'h00}},
    // Best fit, then a tie on the remaining size that the lower slot wins.
    '{1'b1, MODE_BEST, '{CMD_ALLOC, 4'd0, 16'h0000, 16'd60, 8'h07}, 1'b0, NONE},
    '{1'b0, MODE_BEST, '{CMD_LOAD, 4'd7, 16'h3000, 16'd30, 8'h00},
      1'b1, '{STATUS_LOADED, 4'd7, 16'd30, 8'h00}},
    '{1'b0, MODE_BEST, '{CMD_ALLOC, 4'd0, 16'h0000, 16'd30, 8'h08}, 1'b0, NONE},
    // Worst fit, again with a tie on the largest partition.
    '{1'b1, MODE_WORST, '{CMD_ALLOC, 4'd0, 16'h0000, 16'd1, 8'h09}, 1'b0, NONE},
    '{1'b0, MODE_WORST, '{CMD_LOAD, 4'd12, 16'h0100, 16'd999, 8'h00},
      1'b1, '{STATUS_LOADED, 4'd12, 16'd999, 8'h00}},
    '{1'b0, MODE_WORST, '{CMD_ALLOC, 4'd0, 16'h0000, 16'd2, 8'h0A}, 1'b0, NONE},
    '{1'b0, MODE_WORST, '{CMD_ALLOC, 4'd0, 16'h0000, 16'hFFFF, 8'h0B},
      1'b1, '{STATUS_NOFIT, 4'd0, 16'h0000, 8'h0B}},
    // Next fit resumes after the last chosen key, set by the worst fit allocation.
    '{1'b1, MODE_NEXT, '{CMD_ALLOC, 4'd0, 16'h0000, 16'h0000, 8'h0C}, 1'b0, NONE}
  };

  // Random beat: loads refill the table, allocations mostly ask for sizes
  // that fit so that every fit mode gets past the no-fit case.
  function automatic vpa_in_t random_beat();
    vpa_in_t b;
    int unsigned r;
    b.cmd    = ($urandom_range(99) < 35) ? CMD_LOAD : CMD_ALLOC;
    b.slot   = SLOT_W'($urandom_range(PARTITIONS - 1));
    b.job_id = JOB_W'($urandom_range(255));
    case ($urandom_range(3))
      0: b.base_addr = HEAD_W'($urandom());
      // Few distinct heads, so that slots often share a head address and the
      // slot number decides the order.
      1: b.base_addr = {4'($urandom_range(15)), 12'h000};
      2: b.base_addr = HEAD_W'($urandom_range(255));
      default: b.base_addr = 16'hFFFF - HEAD_W'($urandom_range(255));
    endcase
    r = $urandom_range(99);
    if (b.cmd == CMD_LOAD) begin
      if (r < 10)      b.size = 16'hFFFF;
      else if (r < 20) b.size = SIZE_W'($urandom());
      else if (r < 25) b.size = '0;
      else             b.size = SIZE_W'($urandom_range(8191));
    end else begin
      if (r < 8)       b.size = '0;
      else if (r < 15) b.size = SIZE_W'($urandom());
      else if (r < 19) b.size = 16'hFFFF;
      else             b.size = SIZE_W'($urandom_range(1, 2047));
    end
    return b;
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].set_mode) write_fit_mode(DIRECTED[i].mode);
      send_beat(DIRECTED[i].beat, DIRECTED[i].typed, DIRECTED[i].want);
    end

    // Random phases: the first four walk every fit mode in turn, the rest pick
    // one at random. Phases four to six run without any sender gaps.
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_fit_mode((p < 4) ? 2'(p) : 2'($urandom_range(3)));
      gaps_on = !(p >= 3 && p <= 5);
      for (int n = 0; n < PHASE_BEATS; n++) send_beat(random_beat(), 1'b0, NONE);
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    // Any stray result would show up within one allocation time.
    repeat (PARTITIONS + 4) @(posedge clk);
    if (pending_results.size() != 0) fail_count++;

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/vpa_pkg.sv
rtl/vpa_dp.sv
rtl/vpa_ctrl.sv
rtl/variable_partition_allocator.sv
test/tb_top.sv
